@@ rtl/gpsig_pkg.sv @@
// Shared types, constants and quad-slot tables of the grid patch index generator.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gpsig_pkg;

  localparam int unsigned MaxGridResDefault = 126;
  localparam logic [6:0]  GridResReset      = 7'd32;
  localparam logic [6:0]  GridResMin        = 7'd4;

  localparam int unsigned IdxW       = 14;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic CmdInterior = 1'b0;
  localparam logic CmdEdge     = 1'b1;

  // Result strip_side codes
  localparam logic [2:0] StripInterior = 3'd0;

  // Internal side index; strip_side of an edge triangle is this plus one
  localparam logic [1:0] SideTop    = 2'd0;
  localparam logic [1:0] SideBottom = 2'd1;
  localparam logic [1:0] SideLeft   = 2'd2;
  localparam logic [1:0] SideRight  = 2'd3;

  typedef logic [IdxW-1:0] vidx_t;

  typedef struct packed {
    logic       cmd;
    logic [6:0] pos_a;
    logic [6:0] pos_b;
    logic [3:0] stitch_flags;
  } in_item_t;

  typedef struct packed {
    vidx_t      vertex_a;
    vidx_t      vertex_b;
    vidx_t      vertex_c;
    logic [2:0] strip_side;
    logic       last;
  } out_item_t;

  typedef struct packed {
    vidx_t a;
    vidx_t b;
    vidx_t c;
  } tri_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic            edge_step;  // 0: interior cell
    logic            odd;        // edge: i odd; interior: cell parity
    logic            first_step; // i == 1
    logic            last_step;  // i == grid_res - 1
    logic [3:0]      merge;      // stitch per side index
    logic [7:0]      ext;        // extended row length
    vidx_t [3:0]     base;       // top-left corner per side (interior: [0])
  } work_t;

  typedef enum logic [3:0] {
    TriO1  = 4'd0,
    TriO2  = 4'd1,
    TriU   = 4'd2,
    TriF   = 4'd3,
    TriMc  = 4'd4,
    TriIe0 = 4'd5,
    TriIe1 = 4'd6,
    TriIo0 = 4'd7,
    TriIo1 = 4'd8
  } tri_kind_e;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] c;
  } quad_sel_t;

  function automatic quad_sel_t qs(input logic [1:0] a, input logic [1:0] b,
                                   input logic [1:0] c);
    quad_sel_t s;
    s.a = a;
    s.b = b;
    s.c = c;
    return s;
  endfunction

  // Quad slots of each triangle shape per side; the merge vertex sits in .a
  function automatic quad_sel_t quad_sel(input logic [1:0] side, input tri_kind_e kind);
    quad_sel_t s;
    s = qs(2'd0, 2'd0, 2'd0);
    case (kind)
      TriO1: begin
        case (side)
          SideTop:    s = qs(2'd3, 2'd0, 2'd2);
          SideBottom: s = qs(2'd3, 2'd0, 2'd1);
          SideLeft:   s = qs(2'd0, 2'd3, 2'd2);
          default:    s = qs(2'd0, 2'd3, 2'd1);
        endcase
      end
      TriO2: begin
        case (side)
          SideTop:    s = qs(2'd0, 2'd3, 2'd1);
          SideBottom: s = qs(2'd3, 2'd2, 2'd0);
          SideLeft:   s = qs(2'd3, 2'd0, 2'd1);
          default:    s = qs(2'd2, 2'd3, 2'd0);
        endcase
      end
      TriU: begin
        case (side)
          SideTop:    s = qs(2'd0, 2'd2, 2'd1);
          SideBottom: s = qs(2'd1, 2'd3, 2'd2);
          SideLeft:   s = qs(2'd2, 2'd0, 2'd1);
          default:    s = qs(2'd3, 2'd1, 2'd2);
        endcase
      end
      TriF: begin
        case (side)
          SideTop:    s = qs(2'd1, 2'd2, 2'd3);
          SideBottom: s = qs(2'd0, 2'd1, 2'd2);
          SideLeft:   s = qs(2'd2, 2'd1, 2'd3);
          default:    s = qs(2'd1, 2'd0, 2'd2);
        endcase
      end
      TriMc: begin
        case (side)
          SideTop:    s = qs(2'd2, 2'd0, 2'd0);
          SideBottom: s = qs(2'd1, 2'd0, 2'd0);
          SideLeft:   s = qs(2'd2, 2'd0, 2'd0);
          default:    s = qs(2'd1, 2'd0, 2'd0);
        endcase
      end
      TriIe0:  s = qs(2'd0, 2'd2, 2'd3);
      TriIe1:  s = qs(2'd0, 2'd3, 2'd1);
      TriIo0:  s = qs(2'd0, 2'd2, 2'd1);
      TriIo1:  s = qs(2'd1, 2'd2, 2'd3);
      default: s = qs(2'd0, 2'd0, 2'd0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gpsig_front.sv @@
// Front end: input register, row-offset multiplies, range check and corner bases.
// Depends on gpsig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpsig_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [6:0]        grid_res_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gpsig_pkg::in_item_t in_data_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output gpsig_pkg::work_t       push_data_o
);

  logic                s1_valid_q, s1_valid_d;
  gpsig_pkg::in_item_t s1_item_q;
  gpsig_pkg::vidx_t    s1_pe_q;  // pos_a * ext
  gpsig_pkg::vidx_t    s1_re_q;  // grid_res * ext

  logic [7:0] ext;
  logic [7:0] res8;
  logic [7:0] pa8;
  logic [7:0] pb8;
  logic       int_ok;
  logic       edge_ok;
  logic       keep;
  logic       s1_adv;
  logic       in_acc;

  assign res8 = {1'b0, grid_res_i};
  assign ext  = res8 + 8'd2;
  assign pa8  = {1'b0, s1_item_q.pos_a};
  assign pb8  = {1'b0, s1_item_q.pos_b};

  assign int_ok  = (pa8 >= 8'd2) && (pb8 >= 8'd2) &&
                   (pa8 + 8'd2 <= res8) && (pb8 + 8'd2 <= res8);
  assign edge_ok = (pa8 != 8'd0) && (pa8 < res8);
  assign keep    = (s1_item_q.cmd == gpsig_pkg::CmdEdge) ? edge_ok : int_ok;

  assign push_valid_o = s1_valid_q && keep;
  assign s1_adv       = s1_valid_q && (!keep || push_ready_i);
  assign in_ready_o   = !s1_valid_q || s1_adv;
  assign in_acc       = in_valid_i && in_ready_o;

  always_comb begin
    push_data_o.edge_step  = (s1_item_q.cmd == gpsig_pkg::CmdEdge);
    push_data_o.odd        = push_data_o.edge_step ? s1_item_q.pos_a[0]
                                                   : (s1_item_q.pos_a[0] ^ s1_item_q.pos_b[0]);
    push_data_o.first_step = (pa8 == 8'd1);
    push_data_o.last_step  = (pa8 + 8'd1 == res8);
    // flags: bit0 left, bit1 right, bit2 top, bit3 bottom
    push_data_o.merge[gpsig_pkg::SideTop]    = s1_item_q.stitch_flags[2];
    push_data_o.merge[gpsig_pkg::SideBottom] = s1_item_q.stitch_flags[3];
    push_data_o.merge[gpsig_pkg::SideLeft]   = s1_item_q.stitch_flags[0];
    push_data_o.merge[gpsig_pkg::SideRight]  = s1_item_q.stitch_flags[1];
    push_data_o.ext        = ext;
    push_data_o.base[gpsig_pkg::SideTop]    = push_data_o.edge_step
                                              ? s1_pe_q + 14'd1
                                              : s1_pe_q + {7'b0, s1_item_q.pos_b};
    push_data_o.base[gpsig_pkg::SideBottom] = s1_pe_q + {7'b0, grid_res_i} - 14'd1;
    push_data_o.base[gpsig_pkg::SideLeft]   = {6'b0, ext} + {7'b0, s1_item_q.pos_a};
    push_data_o.base[gpsig_pkg::SideRight]  = s1_re_q - {6'b0, ext}
                                              + {7'b0, s1_item_q.pos_a};
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // products kept mod 2^14, which matches the index mask
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
      s1_pe_q   <= 14'({7'b0, in_data_i.pos_a} * {6'b0, ext});
      s1_re_q   <= 14'({7'b0, grid_res_i} * {6'b0, ext});
    end
  end

endmodule

`default_nettype wire

@@ rtl/gpsig_queue.sv @@
// Short request queue between front and back.
// Depends on gpsig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpsig_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire gpsig_pkg::work_t push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output gpsig_pkg::work_t      pop_data_o
);

  gpsig_pkg::work_t                      slot_q [gpsig_pkg::QueueDepth];
  logic [gpsig_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [gpsig_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [gpsig_pkg::QueuePtrW:0]         count_q, count_d;
  logic                                  push;
  logic                                  pop;

  localparam logic [gpsig_pkg::QueuePtrW-1:0] PtrLast =
    gpsig_pkg::QueuePtrW'(gpsig_pkg::QueueDepth - 1);
  localparam logic [gpsig_pkg::QueuePtrW:0] CountFull =
    (gpsig_pkg::QueuePtrW + 1)'(gpsig_pkg::QueueDepth);

  assign push_ready_o = (count_q != CountFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gpsig_back.sv @@
// Back end: walks a request's sides, emits one triangle per cycle into the output
// register unless stalled, holds per-side pending triangles. Depends on gpsig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpsig_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             work_valid_i,
  output logic                  work_ready_o,
  input  wire gpsig_pkg::work_t work_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output gpsig_pkg::out_item_t  out_data_o
);

  logic [1:0]           side_q, side_d;
  logic [1:0]           slot_q, slot_d;
  gpsig_pkg::tri_t      pend_q [4];
  logic                 out_valid_q, out_valid_d;
  gpsig_pkg::out_item_t out_q;

  gpsig_pkg::vidx_t        tl, tl1, bl, bl1;
  gpsig_pkg::vidx_t [3:0]  quad;
  gpsig_pkg::tri_kind_e    kind;
  gpsig_pkg::quad_sel_t    sel, sel_o1, sel_mc;
  gpsig_pkg::tri_t         tri_v, pend_rd;
  logic                    merge;
  logic [1:0]              count;
  logic                    use_pend;
  logic                    emit;
  logic                    fire;
  logic                    side_done;
  logic                    item_done;

  assign tl    = work_i.base[side_q];
  assign tl1   = tl + 14'd1;
  assign bl    = tl + {6'b0, work_i.ext};
  assign bl1   = bl + 14'd1;
  assign merge = work_i.merge[side_q];
  assign pend_rd = pend_q[side_q];

  // corner order of each strip; interior cells use the top order
  always_comb begin
    case (side_q)
      gpsig_pkg::SideBottom: begin
        quad[0] = bl;  quad[1] = bl1; quad[2] = tl;  quad[3] = tl1;
      end
      gpsig_pkg::SideLeft: begin
        quad[0] = tl;  quad[1] = bl;  quad[2] = tl1; quad[3] = bl1;
      end
      gpsig_pkg::SideRight: begin
        quad[0] = tl1; quad[1] = bl1; quad[2] = tl;  quad[3] = bl;
      end
      default: begin
        quad[0] = tl;  quad[1] = tl1; quad[2] = bl;  quad[3] = bl1;
      end
    endcase
  end

  always_comb begin
    if (!work_i.edge_step) begin
      count = 2'd2;
    end else if (work_i.odd) begin
      count = work_i.first_step ? 2'd0 : 2'd1;
    end else begin
      count = (merge ? 2'd1 : 2'd2) + (work_i.last_step ? 2'd0 : 2'd1);
    end
  end

  always_comb begin
    if (!work_i.edge_step) begin
      if (work_i.odd) begin
        kind = (slot_q == 2'd0) ? gpsig_pkg::TriIo0 : gpsig_pkg::TriIo1;
      end else begin
        kind = (slot_q == 2'd0) ? gpsig_pkg::TriIe0 : gpsig_pkg::TriIe1;
      end
    end else if (work_i.odd) begin
      kind = gpsig_pkg::TriO2;
    end else if (slot_q == 2'd1 && !merge) begin
      kind = gpsig_pkg::TriU;
    end else begin
      kind = gpsig_pkg::TriF;
    end
  end

  assign sel    = gpsig_pkg::quad_sel(side_q, kind);
  assign sel_o1 = gpsig_pkg::quad_sel(side_q, gpsig_pkg::TriO1);
  assign sel_mc = gpsig_pkg::quad_sel(side_q, gpsig_pkg::TriMc);

  // even step, first slot: the triangle parked by the previous odd step
  assign use_pend = work_i.edge_step && !work_i.odd && (slot_q == 2'd0);

  always_comb begin
    if (use_pend) begin
      tri_v.a = pend_rd.a;
      tri_v.b = pend_rd.b;
      tri_v.c = merge ? quad[sel_mc.a] : pend_rd.c;
    end else begin
      tri_v.a = quad[sel.a];
      tri_v.b = quad[sel.b];
      tri_v.c = quad[sel.c];
    end
  end

  assign emit      = (count != 2'd0);
  assign fire      = work_valid_i && (!emit || !out_valid_q || out_ready_i);
  assign side_done = !emit || (slot_q == count - 2'd1);
  assign item_done = side_done && (!work_i.edge_step || side_q == gpsig_pkg::SideRight);
  assign work_ready_o = fire && item_done;

  always_comb begin
    side_d = side_q;
    slot_d = slot_q;
    if (fire) begin
      if (side_done) begin
        slot_d = 2'd0;
        side_d = item_done ? gpsig_pkg::SideTop : side_q + 2'd1;
      end else begin
        slot_d = slot_q + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= gpsig_pkg::SideTop;
      slot_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      side_q      <= side_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q.vertex_a   <= tri_v.a;
      out_q.vertex_b   <= tri_v.b;
      out_q.vertex_c   <= tri_v.c;
      out_q.strip_side <= work_i.edge_step ? ({1'b0, side_q} + 3'd1)
                                           : gpsig_pkg::StripInterior;
      out_q.last       <= item_done;
    end
  end

  // pending triangle: set on odd steps, third vertex replaced on a stitched even step
  always_ff @(posedge clk_i) begin
    if (fire && work_i.edge_step && slot_q == 2'd0) begin
      if (work_i.odd) begin
        pend_q[side_q].a <= quad[sel_o1.a];
        pend_q[side_q].b <= quad[sel_o1.b];
        pend_q[side_q].c <= quad[sel_o1.c];
      end else if (merge) begin
        pend_q[side_q].c <= quad[sel_mc.a];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/grid_patch_stitch_index_gen.sv @@
// Grid patch stitch index generator, top level: config register, front, queue, back.
// Depends on gpsig_pkg, gpsig_front, gpsig_queue and gpsig_back.
//
// Usage:
//   in_*  : one request per handshake, cmd 0 = interior cell (pos_a row,
//           pos_b column), cmd 1 = edge step i in pos_a with four stitch flags.
//   out_* : one triangle (three vertex indices, strip side, last) per handshake.
//   cfg_* : grid_res write; values are clamped to 4..MAX_GRID_RES. Write only
//           while no request is in flight. cfg_ready_o is always high.
// Path: the first triangle of a request passes the input register, a queue slot,
//   then the back end into the output register.
// Throughput: the back end emits one triangle per cycle while the output is not
//   stalled. An interior cell gives two triangles, an edge step up to twelve.
//   Each triangle takes one step, or each side one for the first odd step, which
//   only parks triangles. Out-of-range requests are dropped in the front end.
// A 2-entry queue decouples front and back, so new requests keep flowing while
//   the output is stalled, until the queue fills.
// Reset: grid_res returns to 32, queue and output are empty. The parked edge
//   triangles are not cleared; an even step must follow an odd step.
`timescale 1ns / 1ps
`default_nettype none

module grid_patch_stitch_index_gen #(
  parameter int unsigned MAX_GRID_RES = gpsig_pkg::MaxGridResDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [6:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire gpsig_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output gpsig_pkg::out_item_t      out_data_o
);

  logic [6:0]       grid_res_q, grid_res_d;
  logic             q_push_valid, q_push_ready;
  gpsig_pkg::work_t q_push_data;
  logic             q_pop_valid, q_pop_ready;
  gpsig_pkg::work_t q_pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    grid_res_d = grid_res_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i < gpsig_pkg::GridResMin) begin
        grid_res_d = gpsig_pkg::GridResMin;
      end else if (32'(cfg_data_i) > MAX_GRID_RES) begin
        grid_res_d = 7'(MAX_GRID_RES);
      end else begin
        grid_res_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_res_q <= gpsig_pkg::GridResReset;
    end else begin
      grid_res_q <= grid_res_d;
    end
  end

  gpsig_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_res_i   (grid_res_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  gpsig_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  gpsig_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (q_pop_valid),
    .work_ready_o (q_pop_ready),
    .work_i       (q_pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grid_res_q >= gpsig_pkg::GridResMin) && (32'(grid_res_q) <= MAX_GRID_RES))
    else $error("grid_res outside its clamp range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_ready |-> q_pop_valid)
    else $error("back end retired a request from an empty queue");

  a_side_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.strip_side <= 3'd4))
    else $error("invalid strip side on output");

endmodule

`default_nettype wire

@@ tb/grid_patch_stitch_index_gen_tb.sv @@
// Self-checking bench for grid_patch_stitch_index_gen: predicts every triangle of each request
// and checks the results in order across several grid_res settings. Randomly idles both sides.
// Depends on gpsig_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module grid_patch_stitch_index_gen_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 30;

  localparam logic [3:0] StitchLeft   = 4'h1;
  localparam logic [3:0] StitchRight  = 4'h2;
  localparam logic [3:0] StitchTop    = 4'h4;
  localparam logic [3:0] StitchBottom = 4'h8;

  // Quad slot triples per side, packed {right, left, bottom, top}; each triple is {a, b, c}
  localparam logic [23:0] OddPark   = {2'd0, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                       2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd2};
  localparam logic [23:0] OddExtra  = {2'd2, 2'd3, 2'd0, 2'd3, 2'd0, 2'd1,
                                       2'd3, 2'd2, 2'd0, 2'd0, 2'd3, 2'd1};
  localparam logic [23:0] EvenSplit = {2'd3, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1,
                                       2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1};
  localparam logic [23:0] EvenClose = {2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd3,
                                       2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3};
  localparam logic [7:0]  MergeSlot = {2'd1, 2'd2, 2'd1, 2'd2};

  typedef enum logic [2:0] {
    StripCell   = 3'd0,
    StripTop    = 3'd1,
    StripBottom = 3'd2,
    StripLeft   = 3'd3,
    StripRight  = 3'd4
  } strip_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [6:0]            cfg_data = '0;
  logic                  cfg_ready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  gpsig_pkg::in_item_t   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gpsig_pkg::out_item_t  out_data;

  gpsig_pkg::in_item_t   req_backlog[$];
  gpsig_pkg::out_item_t  tri_due[$];
  gpsig_pkg::tri_t       parked_tri[4];
  int unsigned           grid_res_model = gpsig_pkg::GridResReset;

  logic        in_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_stall_pct = 30;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned cfg_writes = 0;
  int unsigned reqs_taken = 0;
  int unsigned busy_reqs = 0;
  int unsigned tris_checked = 0;
  int unsigned merges_seen = 0;

  grid_patch_stitch_index_gen u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic gpsig_pkg::out_item_t make_tri(input int unsigned a, input int unsigned b,
                                                    input int unsigned c, input strip_e strip);
    gpsig_pkg::out_item_t t;
    t.vertex_a   = a[13:0];
    t.vertex_b   = b[13:0];
    t.vertex_c   = c[13:0];
    t.strip_side = strip;
    t.last       = 1'b0;
    return t;
  endfunction

  function automatic gpsig_pkg::out_item_t quad_tri(input gpsig_pkg::vidx_t [3:0] quad,
                                                    input logic [5:0] sel, input strip_e strip);
    return make_tri(quad[sel[5:4]], quad[sel[3:2]], quad[sel[1:0]], strip);
  endfunction

  // Expected triangles of one accepted request; updates the parked edge triangles
  task automatic predict_triangles(input gpsig_pkg::in_item_t it);
    gpsig_pkg::out_item_t   tris[$];
    gpsig_pkg::out_item_t   t;
    gpsig_pkg::vidx_t [3:0] quad;
    int unsigned            r, e, pa, pb, tl, tr, bl, br;
    logic                   merge;
    strip_e                 strip;
    r  = grid_res_model;
    e  = r + 2;
    pa = it.pos_a;
    pb = it.pos_b;
    if (it.cmd == gpsig_pkg::CmdInterior) begin
      if (pa >= 2 && pb >= 2 && pa + 2 <= r && pb + 2 <= r) begin
        tl = pa * e + pb;
        tr = tl + 1;
        bl = tl + e;
        br = bl + 1;
        // diagonal flips with cell parity
        if (((pa + pb) & 1) == 0) begin
          tris.push_back(make_tri(tl, bl, br, StripCell));
          tris.push_back(make_tri(tl, br, tr, StripCell));
        end else begin
          tris.push_back(make_tri(tl, bl, tr, StripCell));
          tris.push_back(make_tri(tr, bl, br, StripCell));
        end
      end
    end else if (pa >= 1 && pa < r) begin
      for (int k = 0; k < 4; k++) begin
        case (k[1:0])
          gpsig_pkg::SideTop: begin
            tl    = pa * e + 1;
            bl    = tl + e;
            quad  = {bl[13:0] + 14'd1, bl[13:0], tl[13:0] + 14'd1, tl[13:0]};
            merge = (it.stitch_flags & StitchTop) != 0;
          end
          gpsig_pkg::SideBottom: begin
            tl    = pa * e + r - 1;
            bl    = tl + e;
            quad  = {tl[13:0] + 14'd1, tl[13:0], bl[13:0] + 14'd1, bl[13:0]};
            merge = (it.stitch_flags & StitchBottom) != 0;
          end
          gpsig_pkg::SideLeft: begin
            tl    = e + pa;
            bl    = tl + e;
            quad  = {bl[13:0] + 14'd1, tl[13:0] + 14'd1, bl[13:0], tl[13:0]};
            merge = (it.stitch_flags & StitchLeft) != 0;
          end
          default: begin
            tl    = (r - 1) * e + pa;
            bl    = tl + e;
            quad  = {bl[13:0], tl[13:0], bl[13:0] + 14'd1, tl[13:0] + 14'd1};
            merge = (it.stitch_flags & StitchRight) != 0;
          end
        endcase
        strip = strip_e'(k + 1);
        if (pa[0]) begin
          // odd step parks one triangle for the next even step
          t = quad_tri(quad, OddPark[k*6 +: 6], strip);
          parked_tri[k].a = t.vertex_a;
          parked_tri[k].b = t.vertex_b;
          parked_tri[k].c = t.vertex_c;
          if (pa != 1) tris.push_back(quad_tri(quad, OddExtra[k*6 +: 6], strip));
        end else begin
          if (merge) begin
            parked_tri[k].c = quad[MergeSlot[k*2 +: 2]];
            merges_seen++;
          end
          tris.push_back(make_tri(parked_tri[k].a, parked_tri[k].b, parked_tri[k].c, strip));
          if (!merge) tris.push_back(quad_tri(quad, EvenSplit[k*6 +: 6], strip));
          if (pa != r - 1) tris.push_back(quad_tri(quad, EvenClose[k*6 +: 6], strip));
        end
      end
    end
    if (tris.size() > 0) tris[tris.size()-1].last = 1'b1;
    foreach (tris[n]) tri_due.push_back(tris[n]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Request driver: holds valid and payload until taken, random gaps between requests
  always @(negedge clk_i) begin : drive_requests
    logic                nv;
    gpsig_pkg::in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_ni) begin
      if (in_valid && in_fire) nv = 1'b0;
      if (!nv && req_backlog.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 5);
        end else begin
          nd = req_backlog.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  always @(negedge clk_i) begin : pace_results
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    gpsig_pkg::out_item_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data < gpsig_pkg::GridResMin) grid_res_model = gpsig_pkg::GridResMin;
        else if (cfg_data > gpsig_pkg::MaxGridResDefault)
          grid_res_model = gpsig_pkg::MaxGridResDefault;
        else grid_res_model = cfg_data;
        cfg_writes++;
      end
      if (out_valid && out_ready) begin
        if (tri_due.size() == 0) begin
          $error("triangle with nothing expected: a=%0d b=%0d c=%0d side=%0d",
                 out_data.vertex_a, out_data.vertex_b, out_data.vertex_c, out_data.strip_side);
          errors++;
        end else begin
          want = tri_due.pop_front();
          check_field("vertex_a", want.vertex_a, out_data.vertex_a);
          check_field("vertex_b", want.vertex_b, out_data.vertex_b);
          check_field("vertex_c", want.vertex_c, out_data.vertex_c);
          check_field("strip_side", want.strip_side, out_data.strip_side);
          check_field("last", want.last, out_data.last);
          tris_checked++;
        end
      end
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_triangles(in_data);
        reqs_taken++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_req(input logic cmd, input int unsigned a, input int unsigned b,
                           input int unsigned flags);
    gpsig_pkg::in_item_t it;
    int unsigned         r;
    r               = grid_res_model;
    it.cmd          = cmd;
    it.pos_a        = a[6:0];
    it.pos_b        = b[6:0];
    it.stitch_flags = flags[3:0];
    req_backlog.push_back(it);
    if (cmd == gpsig_pkg::CmdEdge) begin
      if (a >= 1 && a < r) busy_reqs++;
    end else if (a >= 2 && b >= 2 && a + 2 <= r && b + 2 <= r) begin
      busy_reqs++;
    end
  endtask

  task automatic queue_cell();
    queue_req(gpsig_pkg::CmdInterior, $urandom_range(2, grid_res_model - 2),
              $urandom_range(2, grid_res_model - 2), $urandom_range(0, 15));
  endtask

  task automatic queue_noise();
    queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 127), $urandom_range(0, 127),
              $urandom_range(0, 15));
  endtask

  // Mostly edge passes from i = 1 upward with random stitching; the first pass runs to the end
  task automatic fill_phase(input int unsigned budget);
    int unsigned start, stop, pick, r;
    logic        first;
    start = busy_reqs;
    r     = grid_res_model;
    first = 1'b1;
    while (busy_reqs - start < budget) begin
      pick = $urandom_range(0, 9);
      if (first || pick < 6) begin
        stop  = (first || r <= 25) ? r - 1 : $urandom_range(1, 24);
        first = 1'b0;
        for (int unsigned k = 1; k <= stop; k++) begin
          queue_req(gpsig_pkg::CmdEdge, k, $urandom_range(0, 127), $urandom_range(0, 15));
          if ($urandom_range(0, 4) == 0) queue_cell();
          if ($urandom_range(0, 19) == 0) queue_noise();
        end
      end else if (pick < 8) begin
        queue_cell();
      end else begin
        queue_noise();
      end
    end
  endtask

  task automatic write_grid_res(input logic [6:0] value);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || in_valid || tri_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin : run_plan
    int unsigned plan[$];
    logic [6:0]  next_res;
    plan = '{0, 5, 127, 9, 4};
    wait (rst_ni);
    @(negedge clk_i);

    // directed requests at the reset grid_res of 32
    queue_req(gpsig_pkg::CmdInterior, 2, 2, 0);
    queue_req(gpsig_pkg::CmdInterior, 2, 3, 15);
    queue_req(gpsig_pkg::CmdInterior, 30, 30, 0);
    queue_req(gpsig_pkg::CmdInterior, 30, 29, 0);
    queue_req(gpsig_pkg::CmdInterior, 31, 2, 0);
    queue_req(gpsig_pkg::CmdInterior, 1, 5, 0);
    queue_req(gpsig_pkg::CmdInterior, 0, 0, 0);
    queue_req(gpsig_pkg::CmdInterior, 127, 127, 15);
    queue_req(gpsig_pkg::CmdInterior, 5, 127, 0);
    queue_req(gpsig_pkg::CmdEdge, 0, 0, 15);
    queue_req(gpsig_pkg::CmdEdge, 32, 0, 15);
    queue_req(gpsig_pkg::CmdEdge, 127, 127, 15);
    // first odd step only parks triangles
    queue_req(gpsig_pkg::CmdEdge, 1, 0, 0);
    queue_req(gpsig_pkg::CmdEdge, 2, 0, 0);
    queue_req(gpsig_pkg::CmdEdge, 3, 127, 15);
    queue_req(gpsig_pkg::CmdEdge, 4, 0, 15);
    queue_req(gpsig_pkg::CmdEdge, 5, 0, 5);
    queue_req(gpsig_pkg::CmdEdge, 6, 0, 5);
    queue_req(gpsig_pkg::CmdEdge, 29, 0, 10);
    queue_req(gpsig_pkg::CmdEdge, 30, 0, 10);
    // odd last step: parked triangles stay behind
    queue_req(gpsig_pkg::CmdEdge, 31, 0, 15);

    while (busy_reqs < 340) begin
      settle();
      if (plan.size() > 0) next_res = 7'(plan.pop_front());
      else if ($urandom_range(0, 4) == 0) next_res = 7'($urandom_range(0, 127));
      else next_res = 7'($urandom_range(4, 24));
      write_grid_res(next_res);
      send_idle_pct  = $urandom_range(0, 3) * 15;
      recv_stall_pct = $urandom_range(0, 3) * 15;
      fill_phase(60);
    end

    // closing phase at full rate
    settle();
    write_grid_res(7'($urandom_range(4, 24)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_phase(60);
    settle();

    $display("Took %0d requests (%0d in range), checked %0d triangles, %0d stitched merges.",
             reqs_taken, busy_reqs, tris_checked, merges_seen);
    $display("grid_res written %0d times, clamped extremes included; %0d mismatches.",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
